// ===== rtl/int128_divider_macros.svh =====
// Assertion macros for the divider checker.
`ifndef INT128_DIVIDER_MACROS_SVH
`define INT128_DIVIDER_MACROS_SVH

// Clocked check, off while reset is asserted.
`define DIV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("divider check failed");

// Clocked check that also runs through reset.
`define DIV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("divider check failed");

`endif

// ===== rtl/i128div_pkg.sv =====
// Types and constants shared by the 128-bit divider.
package i128div_pkg;

    localparam int FIELD_BITS = 64;
    localparam int FULL_BITS  = 128;

    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [FIELD_BITS-1:0] dividend_hi;
        logic [FIELD_BITS-1:0] dividend_lo;
        logic [FIELD_BITS-1:0] divisor_hi;
        logic [FIELD_BITS-1:0] divisor_lo;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] quotient_hi;
        logic [FIELD_BITS-1:0] quotient_lo;
        logic [FIELD_BITS-1:0] remainder_hi;
        logic [FIELD_BITS-1:0] remainder_lo;
        logic                  divide_by_zero;
    } out_word_t;

    // Control that rides along with each word through the pipeline.
    typedef struct packed {
        logic valid;
        logic neg_q;
        logic neg_r;
        logic zero;
    } ctl_t;

endpackage

// ===== rtl/int128_divider.sv =====
// Operands pass through the input register, the restoring step registers, the post register
// and the output register before m_valid. Takes one word per cycle while s_ready is high;
// one restoring step per pipeline stage, plus a sign-fix stage at each end and an output register.
// A two-entry output register and skid buffer keep s_ready registered.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
module int128_divider #(
    parameter int WORD_BITS = 128
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  i128div_pkg::in_word_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output i128div_pkg::out_word_t m_data
);

    function automatic logic [WORD_BITS-1:0] negate(input logic [WORD_BITS-1:0] x);
        return ~x + WORD_BITS'(1);
    endfunction

    logic pipe_en;

    // Input stage: mask operands, take magnitudes
    logic [i128div_pkg::FULL_BITS-1:0] a_full, b_full;
    logic [WORD_BITS-1:0]              a_in, b_in;
    logic                              sgn, na, nb;
    i128div_pkg::ctl_t                 pre_ctl_reg, pre_ctl_next;
    logic [WORD_BITS-1:0]              pre_a_reg, pre_a_next;
    logic [WORD_BITS-1:0]              pre_b_reg, pre_b_next;

    always_comb begin
        a_full = {s_data.dividend_hi, s_data.dividend_lo};
        b_full = {s_data.divisor_hi, s_data.divisor_lo};
        a_in   = a_full[WORD_BITS-1:0];
        b_in   = b_full[WORD_BITS-1:0];
        sgn    = (s_data.mode == i128div_pkg::MODE_SIGNED);
        na     = sgn & a_in[WORD_BITS-1];
        nb     = sgn & b_in[WORD_BITS-1];
        pre_a_next = na ? negate(a_in) : a_in;
        pre_b_next = nb ? negate(b_in) : b_in;
        pre_ctl_next.valid = s_valid;
        pre_ctl_next.neg_q = na ^ nb;
        pre_ctl_next.neg_r = na;
        pre_ctl_next.zero  = (b_in == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_ctl_reg <= '0;
        end else if (pipe_en) begin
            pre_ctl_reg <= pre_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pre_a_reg <= pre_a_next;
            pre_b_reg <= pre_b_next;
        end
    end

    // Restoring step chain
    i128div_pkg::ctl_t    ctl_s [WORD_BITS+1];
    logic [WORD_BITS-1:0] rem_s [WORD_BITS+1];
    logic [WORD_BITS-1:0] qn_s  [WORD_BITS+1];
    logic [WORD_BITS-1:0] den_s [WORD_BITS+1];

    assign ctl_s[0] = pre_ctl_reg;
    assign rem_s[0] = '0;
    assign qn_s[0]  = pre_a_reg;
    assign den_s[0] = pre_b_reg;

    for (genvar i = 0; i < WORD_BITS; i++) begin : g_step
        i128div_stage #(
            .WORD_BITS (WORD_BITS)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (pipe_en),
            .ctl_i   (ctl_s[i]),
            .rem_i   (rem_s[i]),
            .qn_i    (qn_s[i]),
            .den_i   (den_s[i]),
            .ctl_o   (ctl_s[i+1]),
            .rem_o   (rem_s[i+1]),
            .qn_o    (qn_s[i+1]),
            .den_o   (den_s[i+1])
        );
    end

    // Output stage: restore signs, force zeros on divide by zero
    i128div_pkg::ctl_t    post_ctl_reg;
    logic [WORD_BITS-1:0] post_q_reg, post_q_next;
    logic [WORD_BITS-1:0] post_r_reg, post_r_next;

    always_comb begin
        if (ctl_s[WORD_BITS].zero) begin
            post_q_next = '0;
            post_r_next = '0;
        end else begin
            post_q_next = ctl_s[WORD_BITS].neg_q ? negate(qn_s[WORD_BITS]) : qn_s[WORD_BITS];
            post_r_next = ctl_s[WORD_BITS].neg_r ? negate(rem_s[WORD_BITS]) : rem_s[WORD_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_ctl_reg <= '0;
        end else if (pipe_en) begin
            post_ctl_reg <= ctl_s[WORD_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            post_q_reg <= post_q_next;
            post_r_reg <= post_r_next;
        end
    end

    // Result word and output register with skid buffer
    logic [i128div_pkg::FULL_BITS-1:0] q_full, r_full;
    i128div_pkg::out_word_t            res_word;
    logic                              item_valid, out_free;
    logic                              out_valid_reg, out_valid_next;
    logic                              skid_valid_reg, skid_valid_next;
    i128div_pkg::out_word_t            out_data_reg, out_data_next;
    i128div_pkg::out_word_t            skid_data_reg, skid_data_next;

    always_comb begin
        q_full = '0;
        r_full = '0;
        q_full[WORD_BITS-1:0] = post_q_reg;
        r_full[WORD_BITS-1:0] = post_r_reg;
        res_word.quotient_hi    = q_full[i128div_pkg::FULL_BITS-1:i128div_pkg::FIELD_BITS];
        res_word.quotient_lo    = q_full[i128div_pkg::FIELD_BITS-1:0];
        res_word.remainder_hi   = r_full[i128div_pkg::FULL_BITS-1:i128div_pkg::FIELD_BITS];
        res_word.remainder_lo   = r_full[i128div_pkg::FIELD_BITS-1:0];
        res_word.divide_by_zero = post_ctl_reg.zero;
    end

    always_comb begin
        pipe_en    = ~skid_valid_reg;
        item_valid = post_ctl_reg.valid & pipe_en;
        out_free   = ~out_valid_reg | m_ready;

        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_free) begin
            out_valid_next  = skid_valid_reg | item_valid;
            out_data_next   = skid_valid_reg ? skid_data_reg : res_word;
            skid_valid_next = 1'b0;
        end else if (item_valid) begin
            // output held; park the word leaving the pipe
            skid_valid_next = 1'b1;
            skid_data_next  = res_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_ready = pipe_en;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== rtl/i128div_stage.sv =====
// One restoring division step with its pipeline register.
module i128div_stage #(
    parameter int WORD_BITS = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  i128div_pkg::ctl_t     ctl_i,
    input  logic [WORD_BITS-1:0]  rem_i,
    input  logic [WORD_BITS-1:0]  qn_i,
    input  logic [WORD_BITS-1:0]  den_i,
    output i128div_pkg::ctl_t     ctl_o,
    output logic [WORD_BITS-1:0]  rem_o,
    output logic [WORD_BITS-1:0]  qn_o,
    output logic [WORD_BITS-1:0]  den_o
);

    i128div_pkg::ctl_t    ctl_reg;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] qn_reg, qn_next;
    logic [WORD_BITS-1:0] den_reg;
    logic [WORD_BITS+1:0] diff;
    logic                 take;

    // qn holds the unconsumed dividend bits on top and the quotient bits below.
    always_comb begin
        diff     = {1'b0, rem_i, qn_i[WORD_BITS-1]} - {2'b00, den_i};
        take     = ~diff[WORD_BITS+1];
        rem_next = take ? diff[WORD_BITS-1:0] : {rem_i[WORD_BITS-2:0], qn_i[WORD_BITS-1]};
        qn_next  = {qn_i[WORD_BITS-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            qn_reg  <= qn_next;
            den_reg <= den_i;
        end
    end

    assign ctl_o = ctl_reg;
    assign rem_o = rem_reg;
    assign qn_o  = qn_reg;
    assign den_o = den_reg;

endmodule

// ===== rtl/i128div_checker.sv =====
// Port-level checks for the divider, bound to the top level.
`include "int128_divider_macros.svh"

module i128div_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input i128div_pkg::out_word_t m_data
);

    logic out_held;
    logic results_zero;

    assign out_held     = m_valid && !m_ready;
    assign results_zero = (m_data.quotient_hi == '0) && (m_data.quotient_lo == '0) &&
                          (m_data.remainder_hi == '0) && (m_data.remainder_lo == '0);

    `DIV_ASSERT(a_hold_stalled, aclk, aresetn, out_held |=> (m_valid && $stable(m_data)))
    `DIV_ASSERT(a_zero_results, aclk, aresetn, (m_valid && m_data.divide_by_zero) |-> results_zero)
    `DIV_ASSERT(a_stall_only_full, aclk, aresetn, !s_ready |-> m_valid)
    `DIV_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (!m_valid && s_ready))

endmodule

bind int128_divider i128div_checker u_i128div_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/int128_divider_tb.sv =====
// Self-checking testbench for the 128-bit signed/unsigned divider.
`timescale 1ns / 1ps

module int128_divider_tb;

    localparam int FULL_BITS    = i128div_pkg::FULL_BITS;
    localparam int FIELD_BITS   = i128div_pkg::FIELD_BITS;
    localparam int LATENCY      = FULL_BITS + 3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 250;

    localparam logic [FULL_BITS-1:0] ALL_ONES = '1;
    localparam logic [FULL_BITS-1:0] SMIN     = {1'b1, {(FULL_BITS-1){1'b0}}};
    localparam logic [FULL_BITS-1:0] SMAX     = {1'b0, {(FULL_BITS-1){1'b1}}};
    localparam logic [FULL_BITS-1:0] ZERO     = '0;
    localparam logic [FULL_BITS-1:0] ONE      = FULL_BITS'(1);

    typedef struct {
        i128div_pkg::in_word_t  stim;
        bit                     typed;
        i128div_pkg::out_word_t want;
    } div_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    i128div_pkg::in_word_t  s_data;
    logic                   m_valid;
    logic                   m_ready;
    i128div_pkg::out_word_t m_data;

    i128div_pkg::out_word_t pending_results[$];
    div_row_t  div_rows[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        stall_sink = 1'b0;

    int128_divider uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic i128div_pkg::in_word_t make_word(logic mode, logic [FULL_BITS-1:0] a,
                                                        logic [FULL_BITS-1:0] b);
        i128div_pkg::in_word_t w;
        w.mode        = mode;
        w.dividend_hi = a[FULL_BITS-1:FIELD_BITS];
        w.dividend_lo = a[FIELD_BITS-1:0];
        w.divisor_hi  = b[FULL_BITS-1:FIELD_BITS];
        w.divisor_lo  = b[FIELD_BITS-1:0];
        return w;
    endfunction

    function automatic i128div_pkg::out_word_t make_result(logic [FULL_BITS-1:0] q,
                                                           logic [FULL_BITS-1:0] r, logic dbz);
        i128div_pkg::out_word_t o;
        o.quotient_hi    = q[FULL_BITS-1:FIELD_BITS];
        o.quotient_lo    = q[FIELD_BITS-1:0];
        o.remainder_hi   = r[FULL_BITS-1:FIELD_BITS];
        o.remainder_lo   = r[FIELD_BITS-1:0];
        o.divide_by_zero = dbz;
        return o;
    endfunction

    // Truncating division: divide magnitudes, then fix signs.
    function automatic i128div_pkg::out_word_t predict_division(i128div_pkg::in_word_t w);
        logic [FULL_BITS-1:0] a, b, q, r;
        logic neg_a, neg_b;
        a = {w.dividend_hi, w.dividend_lo};
        b = {w.divisor_hi, w.divisor_lo};
        if (b == ZERO)
            return make_result(ZERO, ZERO, 1'b1);
        neg_a = (w.mode == i128div_pkg::MODE_SIGNED) && a[FULL_BITS-1];
        neg_b = (w.mode == i128div_pkg::MODE_SIGNED) && b[FULL_BITS-1];
        if (neg_a) a = ZERO - a;
        if (neg_b) b = ZERO - b;
        q = a / b;
        r = a % b;
        if (neg_a ^ neg_b) q = ZERO - q;
        if (neg_a) r = ZERO - r;
        return make_result(q, r, 1'b0);
    endfunction

    function automatic logic [FULL_BITS-1:0] rand_operand();
        logic [FULL_BITS-1:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(7))
            0, 1: ;
            2: v = FULL_BITS'(v[15:0]);
            3: v = FULL_BITS'(v[FIELD_BITS-1:0]);
            4: v = ZERO - FULL_BITS'(v[15:0]);
            5: v = ONE << $urandom_range(FULL_BITS-1);
            6: v = SMIN + FULL_BITS'(v[7:0]);
            default: v = v >> $urandom_range(FULL_BITS-1);
        endcase
        return v;
    endfunction

    task automatic add_row(logic mode, logic [FULL_BITS-1:0] a, logic [FULL_BITS-1:0] b,
                           bit typed, i128div_pkg::out_word_t want);
        div_row_t row;
        row.stim  = make_word(mode, a, b);
        row.typed = typed;
        row.want  = want;
        div_rows.push_back(row);
    endtask

    task automatic send_word(i128div_pkg::in_word_t w, bit typed, i128div_pkg::out_word_t want);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(typed ? want : predict_division(w));
    endtask

    task automatic check_field(string name, logic [FIELD_BITS-1:0] want,
                               logic [FIELD_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sink: random backpressure, or one long hold-off when asked.
    always @(negedge aclk) begin
        if (stall_sink) begin
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
            stall_sink = 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        i128div_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word: expected none, got %h", $time, m_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("quotient_hi", want.quotient_hi, m_data.quotient_hi);
                check_field("quotient_lo", want.quotient_lo, m_data.quotient_lo);
                check_field("remainder_hi", want.remainder_hi, m_data.remainder_hi);
                check_field("remainder_lo", want.remainder_lo, m_data.remainder_lo);
                check_field("divide_by_zero", FIELD_BITS'(want.divide_by_zero),
                            FIELD_BITS'(m_data.divide_by_zero));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [FULL_BITS-1:0] a, b;
        i128div_pkg::out_word_t none;
        int phase;

        none    = make_result(ZERO, ZERO, 1'b0);
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // extremes, zero divisor, wrap case, sign combinations
        add_row(i128div_pkg::MODE_UNSIGNED, ZERO, ONE, 1, make_result(ZERO, ZERO, 1'b0));
        add_row(i128div_pkg::MODE_UNSIGNED, ALL_ONES, ONE, 1, make_result(ALL_ONES, ZERO, 1'b0));
        add_row(i128div_pkg::MODE_UNSIGNED, ALL_ONES, ALL_ONES, 1, make_result(ONE, ZERO, 1'b0));
        add_row(i128div_pkg::MODE_UNSIGNED, ALL_ONES, ZERO, 1, make_result(ZERO, ZERO, 1'b1));
        add_row(i128div_pkg::MODE_SIGNED, SMIN, ZERO, 1, make_result(ZERO, ZERO, 1'b1));
        add_row(i128div_pkg::MODE_UNSIGNED, ZERO, ZERO, 1, make_result(ZERO, ZERO, 1'b1));
        add_row(i128div_pkg::MODE_SIGNED, SMIN, ALL_ONES, 1, make_result(SMIN, ZERO, 1'b0));
        add_row(i128div_pkg::MODE_SIGNED, SMIN, ONE, 1, make_result(SMIN, ZERO, 1'b0));
        add_row(i128div_pkg::MODE_SIGNED, ALL_ONES, ONE, 1, make_result(ALL_ONES, ZERO, 1'b0));
        add_row(i128div_pkg::MODE_SIGNED, SMIN, SMIN, 1, make_result(ONE, ZERO, 1'b0));
        add_row(i128div_pkg::MODE_SIGNED, SMAX, SMIN, 1, make_result(ZERO, SMAX, 1'b0));
        add_row(i128div_pkg::MODE_SIGNED, SMIN, SMAX, 1, make_result(ALL_ONES, ALL_ONES, 1'b0));
        add_row(i128div_pkg::MODE_UNSIGNED, 128'd5, ALL_ONES, 1, make_result(ZERO, 128'd5, 1'b0));
        add_row(i128div_pkg::MODE_SIGNED, ZERO, ALL_ONES, 1, make_result(ZERO, ZERO, 1'b0));
        add_row(i128div_pkg::MODE_SIGNED, 128'd7, ZERO - 128'd2, 0, none);
        add_row(i128div_pkg::MODE_SIGNED, ZERO - 128'd7, 128'd2, 0, none);
        add_row(i128div_pkg::MODE_SIGNED, ZERO - 128'd7, ZERO - 128'd2, 0, none);
        add_row(i128div_pkg::MODE_UNSIGNED, ALL_ONES, SMIN, 0, none);
        add_row(i128div_pkg::MODE_UNSIGNED, SMIN + 128'd5, SMIN + 128'd3, 0, none);
        add_row(i128div_pkg::MODE_UNSIGNED, ALL_ONES, {64'd0, 64'hffff_ffff_ffff_fffb}, 0, none);
        add_row(i128div_pkg::MODE_SIGNED, SMAX, {64'h1, 64'd0}, 0, none);
        add_row(i128div_pkg::MODE_SIGNED, ALL_ONES, SMAX, 0, none);

        foreach (div_rows[i])
            send_word(div_rows[i].stim, div_rows[i].typed, div_rows[i].want);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 8;  recv_idle_pct = 66; end
                1: begin send_idle_pct = 66; recv_idle_pct = 8;  end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    stall_sink    = 1'b1;   // sink holds off; pipeline must back up
                end
            endcase
            repeat (PHASE_ITEMS) begin
                a = rand_operand();
                b = ($urandom_range(99) < 3) ? ZERO : rand_operand();
                send_word(make_word(logic'($urandom_range(1)), a, b), 0, none);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== int128_divider.f =====
+incdir+rtl
rtl/i128div_pkg.sv
rtl/i128div_stage.sv
rtl/int128_divider.sv
rtl/i128div_checker.sv
verif/int128_divider_tb.sv
